### design/crc16_length_prefixed_record_assert.svh
// ---------------------------------------------------------------------------
// crc16_length_prefixed_record_assert.svh
// Assertion macros shared by the record CRC checker.
// ---------------------------------------------------------------------------
`ifndef CRC16_LENGTH_PREFIXED_RECORD_ASSERT_SVH
`define CRC16_LENGTH_PREFIXED_RECORD_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRC16LPR_ASSERT_SAME(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("crc16lpr assertion failed");

// Next-cycle implication, checked outside reset.
`define CRC16LPR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("crc16lpr assertion failed");

// Next-cycle implication, checked at every edge, reset included.
`define CRC16LPR_ASSERT_ALWAYS_NEXT(label, clk_s, ante, cons) \
  label: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("crc16lpr assertion failed");

`endif

### design/crc16lpr_pkg.sv
// ---------------------------------------------------------------------------
// crc16lpr_pkg
// Types, constants and the byte fold for the length-prefixed record CRC.
// ---------------------------------------------------------------------------
package crc16lpr_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Beat held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_beat_t;

  // What the fold stage hands to the output register.
  typedef struct packed {
    logic        emit;
    logic [15:0] crc;
  } result_t;

  // Reflected CRC-16 update, one byte, LSB first.
  function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/crc16lpr_ifs.sv
// ---------------------------------------------------------------------------
// crc16lpr_ifs
// Valid/ready channels: byte stream in, CRC results out.
// ---------------------------------------------------------------------------
interface crc16lpr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface crc16lpr_crc_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

### design/crc16lpr_in_reg.sv
// ---------------------------------------------------------------------------
// crc16lpr_in_reg
// Input register: captures one byte beat, releases it when the fold advances.
// ---------------------------------------------------------------------------
module crc16lpr_in_reg
  import crc16lpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  output logic       in_ready,
  input  logic       advance,
  output in_beat_t   beat
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;

endmodule

### design/crc16lpr_fold.sv
// ---------------------------------------------------------------------------
// crc16lpr_fold
// Record tracking and CRC fold; state moves only when a byte advances.
// ---------------------------------------------------------------------------
module crc16lpr_fold
  import crc16lpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  in_beat_t beat,
  output result_t  result
);

  logic [15:0] crc_r,       crc_nxt;
  logic [7:0]  remain_r,    remain_nxt;
  logic        in_record_r, in_record_nxt;

  logic [15:0] folded;
  logic [7:0]  remain_dec;

  // Length byte folds into the init value; body bytes into the running CRC.
  assign folded     = fold_byte(in_record_r ? crc_r : CRC_INIT, beat.data);
  assign remain_dec = in_record_r ? (remain_r - 8'd1) : (beat.data - 8'd1);

  always_comb begin
    result.emit   = 1'b0;
    result.crc    = folded;
    crc_nxt       = folded;
    remain_nxt    = remain_dec;
    in_record_nxt = 1'b1;
    if (!in_record_r && (beat.data == 8'd0)) begin
      // empty record: nothing folded
      result.emit   = 1'b1;
      result.crc    = CRC_INIT;
      crc_nxt       = CRC_INIT;
      remain_nxt    = 8'd0;
      in_record_nxt = 1'b0;
    end else if (remain_dec == 8'd0) begin
      result.emit   = 1'b1;
      crc_nxt       = CRC_INIT;
      in_record_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      remain_r    <= 8'd0;
      in_record_r <= 1'b0;
    end else if (advance) begin
      crc_r       <= crc_nxt;
      remain_r    <= remain_nxt;
      in_record_r <= in_record_nxt;
    end
  end

endmodule

### design/crc16lpr_out_reg.sv
// ---------------------------------------------------------------------------
// crc16lpr_out_reg
// Result register: holds a CRC beat until the sink takes it.
// ---------------------------------------------------------------------------
module crc16lpr_out_reg
  import crc16lpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     result,
  output logic        slot_free,
  output logic        out_valid,
  output logic [15:0] out_crc,
  input  logic        out_ready
);

  logic        valid_r, valid_nxt;
  logic [15:0] crc_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = (load && result.emit) ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && result.emit) begin
      crc_r <= result.crc;
    end
  end

  assign out_valid = valid_r;
  assign out_crc   = crc_r;

endmodule

### design/crc16_length_prefixed_record.sv
// ---------------------------------------------------------------------------
// crc16_length_prefixed_record
// Length-prefixed record CRC-16 (reflected poly 0xA001, init 0xFFFF).
// ---------------------------------------------------------------------------
//
//   channel | dir | payload          | beat meaning
//   --------+-----+------------------+----------------------------------------
//   in_ch   | in  | data_byte [7:0]  | one record byte; first byte = length
//   out_ch  | out | crc_value [15:0] | CRC of a finished record
//
// Throughput is one byte per cycle while out_ch is not stalled: the 8-bit
// CRC update is a single XOR network between the input register and the
// result register; a record's last byte passes both before its CRC beat leaves.
// rst_n is synchronous: it empties both registers and restarts the record
// tracker waiting for a length byte; no clearing pass.
// A stalled out_ch holds the result register; the input register keeps
// taking one more byte, then in_ch.ready drops until the slot frees.
// ---------------------------------------------------------------------------
module crc16_length_prefixed_record
  import crc16lpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  crc16lpr_byte_if.sink      in_ch,
  crc16lpr_crc_if.source     out_ch
);

  in_beat_t beat;
  result_t  result;
  logic     slot_free;
  logic     advance;

  // The held byte moves through the fold only when the result slot is free,
  // so every byte sees a place for its (possible) CRC beat.
  assign advance = beat.valid && slot_free;

  crc16lpr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.data_byte),
    .in_ready (in_ch.ready),
    .advance  (advance),
    .beat     (beat)
  );

  crc16lpr_fold u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .beat    (beat),
    .result  (result)
  );

  crc16lpr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_crc   (out_ch.crc_value),
    .out_ready (out_ch.ready)
  );

endmodule

### design/crc16lpr_checker.sv
// ---------------------------------------------------------------------------
// crc16lpr_checker
// Port-level checks on the record CRC block, bound to the top level.
// ---------------------------------------------------------------------------
`include "crc16_length_prefixed_record_assert.svh"

module crc16lpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_crc_value
);

  // Input only backs up behind an unaccepted result.
  `CRC16LPR_ASSERT_SAME(a_in_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

  // An offered byte waits unchanged until taken.
  `CRC16LPR_ASSERT_NEXT(a_in_stable, clk, rst_n, in_valid && !in_ready,
    in_valid && (in_data_byte == $past(in_data_byte)))

  // A pending result stays offered.
  `CRC16LPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A stalled result keeps its value.
  `CRC16LPR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
    out_crc_value == $past(out_crc_value))

  // Reset leaves no result behind.
  `CRC16LPR_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind crc16_length_prefixed_record crc16lpr_checker u_crc16lpr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_data_byte  (in_ch.data_byte),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_crc_value (out_ch.crc_value)
);
